// File: rtl/swk_pkg.sv
package swk_pkg;

    localparam int unsigned MAX_STRUCT_BYTES_DEF = 4095;
    localparam logic [7:0]  END_TYPE             = 8'd127;
    localparam logic [7:0]  HEADER_BYTES         = 8'd4;
    localparam int unsigned QUEUE_DEPTH          = 4;
    localparam int unsigned QUEUE_AW             = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       table_start;
    } t_swk_in;

    typedef struct packed {
        logic [7:0]  struct_type;
        logic [7:0]  formatted_length;
        logic [15:0] struct_handle;
        logic [11:0] total_length;
        logic        length_saturated;
        logic        malformed;
        logic        table_end;
    } t_swk_out;

    // classified byte, as queued between front and back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       table_start;
        logic       is_zero;
        logic       is_end;
    } t_swk_tok;

    typedef enum logic [2:0] {
        SWK_PH_TYPE,
        SWK_PH_LEN,
        SWK_PH_HLO,
        SWK_PH_HHI,
        SWK_PH_FMT,
        SWK_PH_STR,
        SWK_PH_ENDED
    } t_swk_phase;

endpackage

// File: rtl/swk_front.sv
module swk_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  swk_pkg::t_swk_in  i_in_data,
    output logic              o_in_stall,
    output logic              o_tok_valid,
    output swk_pkg::t_swk_tok o_tok,
    input  logic              i_q_full
);
    import swk_pkg::*;

    logic     r_valid;
    t_swk_tok r_tok;
    logic     take;

    assign o_in_stall  = r_valid && i_q_full;
    assign take        = i_in_valid && !o_in_stall;
    assign o_tok_valid = r_valid;
    assign o_tok       = r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_tok.data_byte   <= i_in_data.data_byte;
            r_tok.table_start <= i_in_data.table_start;
            r_tok.is_zero     <= (i_in_data.data_byte == 8'd0);
            r_tok.is_end      <= (i_in_data.data_byte == END_TYPE);
        end
    end

endmodule

// File: rtl/swk_queue.sv
module swk_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  swk_pkg::t_swk_tok i_push_tok,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output swk_pkg::t_swk_tok o_tok
);
    import swk_pkg::*;

    t_swk_tok              mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_tok   = mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wr_ptr] <= i_push_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (QUEUE_AW+1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/swk_back.sv
module swk_back #(
    parameter int unsigned MAX_STRUCT_BYTES = swk_pkg::MAX_STRUCT_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  swk_pkg::t_swk_tok i_q_tok,
    output logic              o_q_pop,
    output logic              o_out_valid,
    output swk_pkg::t_swk_out o_out_data,
    input  logic              i_out_stall
);
    import swk_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_STRUCT_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_STRUCT_BYTES);

    t_swk_phase       r_phase,  n_phase;
    logic [CNT_W-1:0] r_cnt,    n_cnt;
    logic [7:0]       r_type,   n_type;
    logic [7:0]       r_len,    n_len;
    logic [15:0]      r_handle, n_handle;
    logic             r_pz,     n_pz;
    logic             r_sat,    n_sat;
    logic             r_out_valid;
    t_swk_out         r_out;

    t_swk_phase       phase_cur;
    logic [CNT_W-1:0] cnt_inc;
    logic             sat_inc;
    logic [7:0]       eff_len;
    logic [CNT_W+11:0] cnt_ext;
    logic             out_free;
    logic             res_valid;
    t_swk_out         res;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_q_pop     = i_q_valid && out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        phase_cur = i_q_tok.table_start ? SWK_PH_TYPE : r_phase;
        sat_inc   = (r_cnt >= CNT_MAX);
        cnt_inc   = sat_inc ? r_cnt : r_cnt + CNT_W'(1);
        cnt_ext   = {12'd0, cnt_inc};
        eff_len   = (r_len < HEADER_BYTES) ? HEADER_BYTES : r_len;

        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_type    = r_type;
        n_len     = r_len;
        n_handle  = r_handle;
        n_pz      = r_pz;
        n_sat     = r_sat;
        res_valid = 1'b0;
        res       = '0;

        if (o_q_pop) begin
            n_phase = phase_cur;
            case (phase_cur)
                SWK_PH_TYPE: begin
                    if (i_q_tok.is_end) begin
                        n_phase       = SWK_PH_ENDED;
                        res_valid     = 1'b1;
                        res.table_end = 1'b1;
                    end else begin
                        n_type   = i_q_tok.data_byte;
                        n_len    = '0;
                        n_handle = '0;
                        n_cnt    = CNT_W'(1);
                        n_sat    = 1'b0;
                        n_pz     = 1'b0;
                        n_phase  = SWK_PH_LEN;
                    end
                end
                SWK_PH_LEN: begin
                    n_len   = i_q_tok.data_byte;
                    n_cnt   = cnt_inc;
                    n_sat   = r_sat | sat_inc;
                    n_phase = SWK_PH_HLO;
                end
                SWK_PH_HLO: begin
                    n_handle = {8'd0, i_q_tok.data_byte};
                    n_cnt    = cnt_inc;
                    n_sat    = r_sat | sat_inc;
                    n_phase  = SWK_PH_HHI;
                end
                SWK_PH_HHI: begin
                    n_handle[15:8] = i_q_tok.data_byte;
                    n_cnt          = cnt_inc;
                    n_sat          = r_sat | sat_inc;
                    n_pz           = 1'b0;
                    n_phase        = (eff_len > HEADER_BYTES) ? SWK_PH_FMT : SWK_PH_STR;
                end
                SWK_PH_FMT: begin
                    n_cnt = cnt_inc;
                    n_sat = r_sat | sat_inc;
                    if (cnt_inc >= CNT_W'(eff_len)) begin
                        n_pz    = 1'b0;
                        n_phase = SWK_PH_STR;
                    end
                end
                SWK_PH_STR: begin
                    n_cnt = cnt_inc;
                    n_sat = r_sat | sat_inc;
                    if (i_q_tok.is_zero && r_pz) begin
                        res_valid            = 1'b1;
                        res.struct_type      = r_type;
                        res.formatted_length = r_len;
                        res.struct_handle    = r_handle;
                        res.total_length     = cnt_ext[11:0];
                        res.length_saturated = r_sat | sat_inc;
                        res.malformed        = (r_len < HEADER_BYTES);
                        n_pz                 = 1'b0;
                        n_phase              = SWK_PH_TYPE;
                    end else begin
                        n_pz = i_q_tok.is_zero;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= SWK_PH_TYPE;
            r_cnt    <= '0;
            r_type   <= '0;
            r_len    <= '0;
            r_handle <= '0;
            r_pz     <= 1'b0;
            r_sat    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_type   <= n_type;
            r_len    <= n_len;
            r_handle <= n_handle;
            r_pz     <= n_pz;
            r_sat    <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= o_q_pop && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && o_q_pop && res_valid) begin
            r_out <= res;
        end
    end

endmodule

// File: rtl/smbios_structure_walker.sv
// SMBIOS structure table walker. Feed the structure table one byte per request
// in address order; each finished structure yields one result request carrying
// type, length byte, handle and total length (saturating at MAX_STRUCT_BYTES,
// reported modulo 4096), and a type 127 structure yields a table-end request,
// after which bytes are dropped until one arrives with table_start set. The
// block takes one byte per clock unless the output stalls: a front register
// classifies each byte, a four-entry queue carries it to the walker, and the
// walker's phase machine and byte counter take each byte into a registered
// output. A closing byte passes the front register and a queue entry first.
// The queue absorbs a stalled output; input stall rises only once it is full.
module smbios_structure_walker #(
    parameter int unsigned MAX_STRUCT_BYTES = swk_pkg::MAX_STRUCT_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  swk_pkg::t_swk_in  i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output swk_pkg::t_swk_out o_out_data,
    input  logic              i_out_stall
);
    import swk_pkg::*;

    // front -> queue
    logic     tok_valid;
    t_swk_tok tok;
    logic     q_full;

    // queue -> back
    logic     q_valid;
    t_swk_tok q_tok;
    logic     q_pop;

    swk_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_tok_valid (tok_valid),
        .o_tok       (tok),
        .i_q_full    (q_full)
    );

    swk_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (tok_valid),
        .i_push_tok (tok),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_tok      (q_tok)
    );

    // walker: phase machine, counter and output register
    swk_back #(
        .MAX_STRUCT_BYTES (MAX_STRUCT_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_tok     (q_tok),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
